// File: rtl/core/csu_pkg.sv
// Package of types, codes and decode functions for the capability string unescaper.
`default_nettype none

package csu_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0] ChZero   = 8'h00;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChColon  = 8'h3A;
    localparam logic [7:0] ChCaret  = 8'h5E;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChDigit0 = 8'h30;
    localparam logic [7:0] ChDigit9 = 8'h39;
    localparam logic [7:0] CtrlMask = 8'h1F;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_CARET  = 3'd1,
        MODE_ESC    = 3'd2,
        MODE_OCT1   = 3'd3,
        MODE_OCT2   = 3'd4,
        MODE_DONE   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_res;

    typedef struct packed {
        logic       emit;
        t_res       res;
        t_mode      mode;
        logic       quotes;
        logic       seg;
    } t_norm;

    typedef struct packed {
        logic       hit;
        logic [7:0] data;
    } t_esc;

    // Decoding of one byte in normal mode.
    function automatic t_norm decode_normal(input logic [7:0] b, input logic seg,
                                            input logic quotes);
        t_norm r;
        r.emit     = 1'b0;
        r.res.data = b;
        r.res.last = 1'b0;
        r.mode     = MODE_NORMAL;
        r.quotes   = quotes;
        r.seg      = 1'b0;
        if (seg && !quotes && b == ChQuote) begin
            r.quotes = 1'b1;
        end else if (b == ChZero) begin
            r.emit     = 1'b1;
            r.res.data = ChZero;
            r.res.last = 1'b1;
            r.mode     = MODE_DONE;
        end else if (quotes && b == ChQuote) begin
            r.quotes = 1'b0;
            r.seg    = 1'b1;
        end else if (!quotes && b == ChColon) begin
            r.emit     = 1'b1;
            r.res.data = ChZero;
            r.res.last = 1'b1;
            r.mode     = MODE_DONE;
        end else if (b == ChCaret) begin
            r.mode = MODE_CARET;
        end else if (b == ChBslash) begin
            r.mode = MODE_ESC;
        end else begin
            r.emit = 1'b1;
        end
        return r;
    endfunction

    // Mapping of the byte that follows a backslash.
    function automatic t_esc escape_map(input logic [7:0] b);
        t_esc r;
        r.hit  = 1'b1;
        r.data = b;
        unique case (b)
            8'h45:   r.data = 8'h1B;
            8'h5E:   r.data = b;
            8'h5C:   r.data = b;
            8'h3A:   r.data = b;
            8'h6E:   r.data = 8'h0A;
            8'h72:   r.data = 8'h0D;
            8'h74:   r.data = 8'h09;
            8'h62:   r.data = 8'h08;
            8'h66:   r.data = 8'h0C;
            8'h22:   r.data = b;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/capability_string_unescaper.sv
// Top level of the capability string unescaper: input register, decoder and result queue.
//
//  Channel | Direction | tdata           | tuser / tlast
//  s       | in        | [7:0] in_byte   | tuser[0] first
//  m       | out       | [7:0] out_byte  | tlast last
//
// One byte is accepted per cycle while the input side is not held; its results pass
// through the input register into the result queue, which holds four results.
// A byte with two results drains at the output one result per cycle while it is ready.
// Reset is synchronous and active low and returns the decoder to normal mode.
// The input register is released only while the queue has room for two results,
// so under an output stall the input side is held once three results are waiting.
`default_nettype none

module capability_string_unescaper (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tuser,   // [0] first
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic            o_m_tlast
);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_first;

    csu_pkg::t_mode             r_mode, n_mode;
    logic                       r_quotes, n_quotes;
    logic                       r_seg, n_seg;
    logic [9:0]                 r_acc, n_acc;

    csu_pkg::t_res              r_q [csu_pkg::QDepth];
    logic [csu_pkg::QPtrW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [csu_pkg::QCntW-1:0]  r_count, n_count;

    logic                       w_proc, w_pop, w_take;
    logic                       w_push0, w_push1;
    csu_pkg::t_res              w_res0, w_res1;
    csu_pkg::t_mode             w_mode_c;
    logic                       w_quotes_c, w_seg_c;
    logic [9:0]                 w_acc_c, w_acc_dig;
    logic                       w_digit;
    csu_pkg::t_norm             w_nr;
    csu_pkg::t_esc              w_esc;
    logic [csu_pkg::QPtrW-1:0]  w_wr_ptr1;

    assign w_proc     = r_in_valid && (r_count <= csu_pkg::QCntW'(csu_pkg::QDepth - 2));
    assign o_s_tready = !r_in_valid || w_proc;
    assign w_take     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_count != '0);
    assign w_pop      = o_m_tvalid && i_m_tready;
    assign o_m_tdata  = r_q[r_rd_ptr].data;
    assign o_m_tlast  = r_q[r_rd_ptr].last;
    assign w_wr_ptr1  = r_wr_ptr + 1'b1;

    always_comb begin
        w_mode_c   = r_in_first ? csu_pkg::MODE_NORMAL : r_mode;
        w_quotes_c = r_in_first ? 1'b0 : r_quotes;
        w_seg_c    = r_in_first ? 1'b1 : r_seg;
        w_acc_c    = r_in_first ? 10'd0 : r_acc;
        w_digit    = (r_in_byte >= csu_pkg::ChDigit0) && (r_in_byte <= csu_pkg::ChDigit9);
        w_acc_dig  = {w_acc_c[6:0], 3'b000} | {6'd0, r_in_byte[3:0]};
        w_nr       = csu_pkg::decode_normal(r_in_byte, w_seg_c, w_quotes_c);
        w_esc      = csu_pkg::escape_map(r_in_byte);

        n_mode   = w_mode_c;
        n_quotes = w_quotes_c;
        n_seg    = w_seg_c;
        n_acc    = w_acc_c;
        w_push0  = 1'b0;
        w_push1  = 1'b0;
        w_res0   = w_nr.res;
        w_res1   = w_nr.res;

        unique case (w_mode_c)
            csu_pkg::MODE_NORMAL: begin
                w_push0  = w_nr.emit;
                n_mode   = w_nr.mode;
                n_quotes = w_nr.quotes;
                n_seg    = w_nr.seg;
            end
            csu_pkg::MODE_CARET: begin
                w_push0     = 1'b1;
                w_res0.data = r_in_byte & csu_pkg::CtrlMask;
                w_res0.last = 1'b0;
                n_mode      = csu_pkg::MODE_NORMAL;
            end
            csu_pkg::MODE_ESC: begin
                if (!w_esc.hit && w_digit) begin
                    n_acc  = {6'd0, r_in_byte[3:0]};
                    n_mode = csu_pkg::MODE_OCT1;
                end else begin
                    w_push0     = 1'b1;
                    w_res0.data = w_esc.data;
                    w_res0.last = 1'b0;
                    n_mode      = csu_pkg::MODE_NORMAL;
                end
            end
            csu_pkg::MODE_OCT1, csu_pkg::MODE_OCT2: begin
                if (w_digit) begin
                    n_acc = w_acc_dig;
                    if (w_mode_c == csu_pkg::MODE_OCT1) begin
                        n_mode = csu_pkg::MODE_OCT2;
                    end else begin
                        w_push0     = 1'b1;
                        w_res0.data = w_acc_dig[7:0];
                        w_res0.last = 1'b0;
                        n_mode      = csu_pkg::MODE_NORMAL;
                    end
                end else begin
                    w_push0     = 1'b1;
                    w_res0.data = w_acc_c[7:0];
                    w_res0.last = 1'b0;
                    w_push1     = w_nr.emit;
                    n_mode      = w_nr.mode;
                    n_quotes    = w_nr.quotes;
                    n_seg       = w_nr.seg;
                end
            end
            default: begin
                n_mode = csu_pkg::MODE_DONE;
            end
        endcase

        if (!w_proc) begin
            w_push0 = 1'b0;
            w_push1 = 1'b0;
        end
        n_count = r_count + csu_pkg::QCntW'(w_push0) + csu_pkg::QCntW'(w_push1)
                  - csu_pkg::QCntW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= csu_pkg::MODE_NORMAL;
            r_quotes   <= 1'b0;
            r_seg      <= 1'b1;
            r_acc      <= 10'd0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_proc) begin
                r_mode   <= n_mode;
                r_quotes <= n_quotes;
                r_seg    <= n_seg;
                r_acc    <= n_acc;
            end
            if (w_push0 && w_push1) begin
                r_wr_ptr <= r_wr_ptr + 2'd2;
            end else if (w_push0) begin
                r_wr_ptr <= w_wr_ptr1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte  <= i_s_tdata;
            r_in_first <= i_s_tuser;
        end
        if (w_push0) begin
            r_q[r_wr_ptr] <= w_res0;
        end
        if (w_push1) begin
            r_q[w_wr_ptr1] <= w_res1;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= csu_pkg::QCntW'(csu_pkg::QDepth))
        else $error("result queue count out of range");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_proc) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("pending input byte lost while the queue was full");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push0 && w_res0.last) |=> (r_mode == csu_pkg::MODE_DONE))
        else $error("decoder did not finish after the terminating zero");

endmodule

`default_nettype wire

// File: test/unescape_checker.sv
`timescale 1ns / 1ps
// Checker for the capability string unescaper: tracks decoder state per request and checks results.
module unescape_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tuser,   // [0] first
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  wire logic       i_m_tlast,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked,
    output int              o_double_count
);

    localparam logic [7:0] KeyEsc = "E";
    localparam logic [7:0] KeyNl  = "n";
    localparam logic [7:0] KeyCr  = "r";
    localparam logic [7:0] KeyTab = "t";
    localparam logic [7:0] KeyBs  = "b";
    localparam logic [7:0] KeyFf  = "f";

    localparam logic [7:0] CodeEsc = 8'h1B;
    localparam logic [7:0] CodeNl  = 8'h0A;
    localparam logic [7:0] CodeCr  = 8'h0D;
    localparam logic [7:0] CodeTab = 8'h09;
    localparam logic [7:0] CodeBs  = 8'h08;
    localparam logic [7:0] CodeFf  = 8'h0C;

    csu_pkg::t_mode dec_mode;
    logic           quoted;
    logic           seg_open;
    logic [9:0]     octal_value;
    csu_pkg::t_res  decoded_q[$];

    task automatic clear_state();
        dec_mode    = csu_pkg::MODE_NORMAL;
        quoted      = 1'b0;
        seg_open    = 1'b1;
        octal_value = '0;
    endtask

    task automatic push_decoded(input logic [7:0] d, input logic l);
        decoded_q.push_back(csu_pkg::t_res'{data: d, last: l});
    endtask

    task automatic decode_plain(input logic [7:0] b);
        if (seg_open && !quoted && b == csu_pkg::ChQuote) begin
            quoted   = 1'b1;
            seg_open = 1'b0;
        end else begin
            seg_open = 1'b0;
            if (b == csu_pkg::ChZero || (!quoted && b == csu_pkg::ChColon)) begin
                push_decoded(csu_pkg::ChZero, 1'b1);
                dec_mode = csu_pkg::MODE_DONE;
            end else if (quoted && b == csu_pkg::ChQuote) begin
                quoted   = 1'b0;
                seg_open = 1'b1;
            end else if (b == csu_pkg::ChCaret) begin
                dec_mode = csu_pkg::MODE_CARET;
            end else if (b == csu_pkg::ChBslash) begin
                dec_mode = csu_pkg::MODE_ESC;
            end else begin
                push_decoded(b, 1'b0);
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic first);
        logic [7:0] diff;
        logic [3:0] digit;
        logic       is_num;
        if (first) begin
            clear_state();
        end
        diff   = b - csu_pkg::ChDigit0;
        digit  = diff[3:0];
        is_num = (b >= csu_pkg::ChDigit0) && (b <= csu_pkg::ChDigit9);
        case (dec_mode)
            csu_pkg::MODE_NORMAL: begin
                decode_plain(b);
            end
            csu_pkg::MODE_CARET: begin
                push_decoded(b & csu_pkg::CtrlMask, 1'b0);
                dec_mode = csu_pkg::MODE_NORMAL;
            end
            csu_pkg::MODE_ESC: begin
                dec_mode = csu_pkg::MODE_NORMAL;
                case (b)
                    KeyEsc: push_decoded(CodeEsc, 1'b0);
                    KeyNl:  push_decoded(CodeNl, 1'b0);
                    KeyCr:  push_decoded(CodeCr, 1'b0);
                    KeyTab: push_decoded(CodeTab, 1'b0);
                    KeyBs:  push_decoded(CodeBs, 1'b0);
                    KeyFf:  push_decoded(CodeFf, 1'b0);
                    csu_pkg::ChCaret, csu_pkg::ChBslash, csu_pkg::ChColon,
                    csu_pkg::ChQuote: push_decoded(b, 1'b0);
                    default: begin
                        if (is_num) begin
                            octal_value = {6'b0, digit};
                            dec_mode    = csu_pkg::MODE_OCT1;
                        end else begin
                            push_decoded(b, 1'b0);
                        end
                    end
                endcase
            end
            csu_pkg::MODE_OCT1, csu_pkg::MODE_OCT2: begin
                if (is_num) begin
                    // Digits eight and nine are merged with all four bits.
                    octal_value = {octal_value[6:0], 3'b000} | {6'b0, digit};
                    if (dec_mode == csu_pkg::MODE_OCT1) begin
                        dec_mode = csu_pkg::MODE_OCT2;
                    end else begin
                        push_decoded(octal_value[7:0], 1'b0);
                        dec_mode = csu_pkg::MODE_NORMAL;
                    end
                end else begin
                    push_decoded(octal_value[7:0], 1'b0);
                    dec_mode = csu_pkg::MODE_NORMAL;
                    decode_plain(b);
                end
            end
            default: begin
                dec_mode = csu_pkg::MODE_DONE;
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        csu_pkg::t_res want;
        int            depth;
        if (!i_rst_n) begin
            clear_state();
            decoded_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: out_byte %02h last %b", i_m_tdata, i_m_tlast);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = decoded_q.pop_front();
                    o_checked = o_checked + 1;
                    if (i_m_tdata !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, i_m_tdata);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, i_m_tlast);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                depth = decoded_q.size();
                predict_byte(i_s_tdata, i_s_tuser);
                if (decoded_q.size() - depth == 2) begin
                    o_double_count = o_double_count + 1;
                end
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the capability string unescaper testbench: stimulus, handshakes and verdict.
module testbench;

    localparam int CycleLimit  = 400000;
    localparam int RandomItems = 1950;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] in_byte
    logic       s_tuser  = 1'b0; // [0] first
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [7:0] out_byte
    logic       m_tlast;
    logic       s_taken  = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int double_count;
    int cycles        = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic start_flag  = 1'b0;

    capability_string_unescaper i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    unescape_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_double_count (double_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        s_taken <= s_tvalid && s_tready;
        cycles  <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(negedge clk) begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Holds the request until a handshake has been seen at a rising edge.
    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = first;
        @(negedge clk);
        while (!s_taken) begin
            @(negedge clk);
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        send_byte(b, start_flag);
        start_flag = 1'b0;
        items_sent = items_sent + 1;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (b == csu_pkg::ChColon) begin
            b = 8'h41;
        end
        return b;
    endfunction

    function automatic logic [7:0] escape_letter(input int idx);
        case (idx)
            0:       return "E";
            1:       return csu_pkg::ChCaret;
            2:       return csu_pkg::ChBslash;
            3:       return csu_pkg::ChColon;
            4:       return "n";
            5:       return "r";
            6:       return "t";
            7:       return "b";
            8:       return "f";
            default: return csu_pkg::ChQuote;
        endcase
    endfunction

    task automatic send_quoted();
        logic [7:0] b;
        put_byte(csu_pkg::ChQuote);
        repeat ($urandom_range(0, 4)) begin
            b = ($urandom_range(0, 2) == 0) ? csu_pkg::ChColon
                                            : 8'($urandom_range(8'h20, 8'h7E));
            put_byte((b == csu_pkg::ChQuote) ? csu_pkg::ChColon : b);
        end
        put_byte(csu_pkg::ChQuote);
    endtask

    task automatic send_token();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            put_byte(plain_byte());
        end else if (kind < 52) begin
            put_byte(csu_pkg::ChCaret);
            put_byte(8'($urandom_range(0, 255)));
        end else if (kind < 67) begin
            put_byte(csu_pkg::ChBslash);
            put_byte(escape_letter($urandom_range(0, 9)));
        end else if (kind < 85) begin
            put_byte(csu_pkg::ChBslash);
            repeat ($urandom_range(1, 3)) begin
                put_byte(csu_pkg::ChDigit0 + 8'($urandom_range(0, 9)));
            end
        end else if (kind < 93) begin
            put_byte(csu_pkg::ChBslash);
            put_byte(8'($urandom_range(0, 255)));
        end else begin
            put_byte(csu_pkg::ChQuote);
        end
    endtask

    task automatic send_random_value();
        int kind;
        start_flag = 1'b1;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 8)) begin
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                items_sent = items_sent + 1;
            end
        end else if (kind < 16) begin
            // A quoted segment that runs into the zero byte.
            put_byte(csu_pkg::ChQuote);
            repeat ($urandom_range(0, 5)) begin
                put_byte(($urandom_range(0, 1) == 0) ? csu_pkg::ChColon : 8'h61);
            end
            put_byte(csu_pkg::ChZero);
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 2)) send_quoted();
            end
            repeat ($urandom_range(0, 8)) send_token();
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                put_byte(csu_pkg::ChColon);
            end else if (kind < 88) begin
                put_byte(csu_pkg::ChZero);
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
                items_sent = items_sent + 1;
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // The first value follows reset without a first marker.
        put_text("\"x:\"^?q\"\\E\\101\\7z:");
        send_byte(8'hFF, 1'b0);
        items_sent = items_sent + 1;
        start_flag = 1'b1;
        put_byte(csu_pkg::ChZero);
        start_flag = 1'b1;
        put_byte(csu_pkg::ChBslash);
        put_byte(csu_pkg::ChZero);
        put_byte(csu_pkg::ChCaret);
        put_byte(csu_pkg::ChZero);
        put_text("\\98:");
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            int target;
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 56 : 0;
            recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 19 : 0;
            target = items_sent + RandomItems / 3;
            while (items_sent < target) begin
                send_random_value();
            end
            wait_drained();
        end

        repeat (10) @(negedge clk);
        $display("summary: %0d bytes sent, %0d decoded bytes checked, %0d bytes gave two results",
                 items_sent, checked, double_count);
        $display("summary: three handshake pressure phases, %0d mismatches", fail_count);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/csu_pkg.sv
rtl/core/capability_string_unescaper.sv
test/unescape_checker.sv
test/testbench.sv
